@@ rtl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Operation codes, status codes and transaction payload types shared by the
// ordered list engine and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int MIDX_W   = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 3'd0,
        FUNC_SEARCH = 3'd1,
        FUNC_DELETE = 3'd2,
        FUNC_INSERT = 3'd3,
        FUNC_POP    = 3'd4,
        FUNC_CLEAR  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [MIDX_W-1:0]    match_index;
        logic [COUNT_W-1:0]   count;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/ole_if.sv @@
// ----------------------------------------------------------------------------
// ole_if
// Valid/ready channels of the ordered list engine: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ole_req_if;
    logic                                valid;
    logic                                ready;
    logic [ole_pkg::FUNC_W-1:0]          func;
    logic signed [ole_pkg::VALUE_W-1:0]  value;
    logic [ole_pkg::POS_W-1:0]           position;

    modport source (output valid, output func, output value, output position,
                    input ready);
    modport sink   (input valid, input func, input value, input position,
                    output ready);
endinterface

interface ole_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [ole_pkg::STATUS_W-1:0]        status;
    logic                                found;
    logic [ole_pkg::MIDX_W-1:0]          match_index;
    logic [ole_pkg::COUNT_W-1:0]         count;

    modport source (output valid, output status, output found,
                    output match_index, output count, input ready);
    modport sink   (input valid, input status, input found,
                    input match_index, input count, output ready);
endinterface

`default_nettype wire

@@ rtl/ole_core.sv @@
// ----------------------------------------------------------------------------
// ole_core
// List storage and sequencer. Entries live in a memory with one write port
// and one registered read port; search, delete and insert walk it one entry
// per cycle through a single read/compare/write path.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ole_pkg::req_t req,
    input  wire logic          req_valid,
    output logic               req_ready,
    output ole_pkg::rsp_t      rsp,
    output logic               rsp_valid,
    input  wire logic          rsp_take
);
    import ole_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DELETE,
        S_INSERT,
        S_RESULT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   idx_reg;
    logic            pend_reg;
    logic [AW-1:0]   pend_addr_reg;
    logic [AW-1:0]   pos_reg;
    logic [SW-1:0]   val_reg;
    status_t         status_reg;
    logic            found_reg;
    logic [AW-1:0]   midx_reg;
    logic [SW-1:0]   rdata_reg;
    logic [SW-1:0]   mem [CAPACITY];

    logic            start;
    logic            list_empty;
    logic            is_full;
    logic            hit;
    logic            more;
    logic            ins_more;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [SW-1:0]   wr_data;

    assign start      = req_valid && (state_reg == S_IDLE);
    assign list_empty = (cnt_reg == '0);
    assign is_full    = (cnt_reg == CW'(CAPACITY));
    assign pos_x      = CMPW'(req.position);
    assign cnt_x      = CMPW'(cnt_reg);
    // In search the pending flag marks that read data for pend_addr is ready.
    assign hit        = pend_reg && (rdata_reg == val_reg);
    assign more       = (idx_reg < cnt_reg);
    assign ins_more   = (idx_reg > CW'(pos_reg));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = AW'(idx_reg);
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = rdata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (req.func == FUNC_APPEND) && !is_full)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cnt_reg);
                    wr_data = req.value[SW-1:0];
                end
            end
            S_SEARCH:
            begin
                rd_en = !hit && more;
            end
            S_DELETE:
            begin
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg - AW'(1);
                rd_en   = more;
            end
            S_INSERT:
            begin
                rd_en   = ins_more;
                rd_addr = AW'(idx_reg - CW'(1));
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg + AW'(1);
                end
                else if (!ins_more)
                begin
                    // All later entries have moved up; drop the new word in.
                    wr_en   = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = val_reg;
                end
            end
            S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            status_reg    <= ST_OK;
            found_reg     <= 1'b0;
            midx_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        status_reg <= ST_OK;
                        found_reg  <= 1'b0;
                        midx_reg   <= '0;
                        pend_reg   <= 1'b0;
                        val_reg    <= req.value[SW-1:0];
                        pos_reg    <= AW'(req.position);
                        state_reg  <= S_RESULT;
                        unique case (req.func)
                            FUNC_APPEND:
                            begin
                                if (is_full)
                                    status_reg <= ST_FULL;
                                else
                                    cnt_reg <= cnt_reg + CW'(1);
                            end
                            FUNC_SEARCH:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_SEARCH;
                            end
                            FUNC_DELETE:
                            begin
                                if (list_empty)
                                    status_reg <= ST_EMPTY;
                                else if (pos_x >= cnt_x)
                                    status_reg <= ST_RANGE;
                                else
                                begin
                                    idx_reg   <= CW'(req.position) + CW'(1);
                                    state_reg <= S_DELETE;
                                end
                            end
                            FUNC_INSERT:
                            begin
                                if (list_empty)
                                    status_reg <= ST_EMPTY;
                                else if (is_full)
                                    status_reg <= ST_FULL;
                                else if (pos_x > cnt_x)
                                    status_reg <= ST_RANGE;
                                else
                                begin
                                    idx_reg   <= cnt_reg;
                                    state_reg <= S_INSERT;
                                end
                            end
                            FUNC_POP:
                            begin
                                if (list_empty)
                                    status_reg <= ST_EMPTY;
                                else
                                    cnt_reg <= cnt_reg - CW'(1);
                            end
                            FUNC_CLEAR:
                            begin
                                cnt_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        midx_reg  <= pend_addr_reg;
                        state_reg <= S_RESULT;
                    end
                    else if (more)
                    begin
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= AW'(idx_reg);
                        idx_reg       <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_DELETE:
                begin
                    if (more)
                    begin
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= AW'(idx_reg);
                        idx_reg       <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        // The last pending move is written at this same edge.
                        pend_reg  <= 1'b0;
                        cnt_reg   <= cnt_reg - CW'(1);
                        state_reg <= S_RESULT;
                    end
                end
                S_INSERT:
                begin
                    if (ins_more)
                    begin
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= AW'(idx_reg - CW'(1));
                        idx_reg       <= idx_reg - CW'(1);
                    end
                    else if (pend_reg)
                    begin
                        pend_reg <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (rsp_take)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign rsp_valid       = (state_reg == S_RESULT);
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.match_index = MIDX_W'(midx_reg);
    assign rsp.count       = COUNT_W'(cnt_reg);

endmodule

`default_nettype wire

@@ rtl/ordered_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered list of signed words with append, search, delete, insert, pop and
// clear, one result transaction per request transaction.
//
//   Channel  Role    Payload
//   req      sink    func, value, position
//   rsp      source  status, found, match_index, count
//
// Append, pop, clear and rejected requests are settled as the request is
// taken; search, delete and insert walk the entry memory one entry per
// cycle on its single read port. A new request is taken once the sequencer
// has passed its result to the output register, which may still be waiting
// on rsp.ready. Reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ole_req_if.sink   req,
    ole_rsp_if.source rsp
);
    import ole_pkg::*;

    req_t core_req;
    rsp_t core_rsp;
    logic core_ready;
    logic core_rsp_valid;
    logic take;
    logic out_valid_reg;
    rsp_t out_reg;

    assign core_req.func     = req.func;
    assign core_req.value    = req.value;
    assign core_req.position = req.position;
    assign req.ready         = core_ready;

    assign take = core_rsp_valid && (!out_valid_reg || rsp.ready);

    ole_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (core_req),
        .req_valid (req.valid),
        .req_ready (core_ready),
        .rsp       (core_rsp),
        .rsp_valid (core_rsp_valid),
        .rsp_take  (take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= core_rsp;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.found       = out_reg.found;
    assign rsp.match_index = out_reg.match_index;
    assign rsp.count       = out_reg.count;

endmodule

`default_nettype wire
